// ===== hdl/rnp_pkg.sv =====
// Shared types, codes and character helpers for the radix number parser.
package rnp_pkg;

	// Result status codes
	localparam logic [1:0] ST_TOO_MANY  = 2'd0;
	localparam logic [1:0] ST_NO_NUMBER = 2'd1;
	localparam logic [1:0] ST_OTHER     = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] CFG_RADIX       = 2'd0;
	localparam logic [1:0] CFG_MAX_DIGITS  = 2'd1;
	localparam logic [1:0] CFG_ALLOW_MINUS = 2'd2;

	// Reset values of the configuration registers
	localparam logic [5:0] RADIX_RESET      = 6'd10;
	localparam logic [5:0] MAX_DIGITS_RESET = 6'd10;
	localparam logic       ALLOW_MINUS_RESET = 1'b1;

	// Usable range of the base
	localparam logic [5:0] RADIX_MIN = 6'd2;
	localparam logic [5:0] RADIX_MAX = 6'd36;

	// ASCII characters of interest
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_Z = 8'h7A;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CH_MINUS   = 8'h2D;
	localparam logic [5:0] LETTER_BASE = 6'd10;

	// One classified byte as it travels from the front end to the back end.
	typedef struct packed {
		logic [7:0] char_in;
		logic       restart;
		logic       is_digit;  // a digit whose value is below the base
		logic [5:0] digit;
		logic       minus_ok;  // a minus sign that may set the sign flag
	} rnp_item_t;

	// Base with out-of-range settings pulled into 2..36.
	function automatic logic [5:0] clamp_radix(input logic [5:0] r);
		logic [5:0] res;
		res = r;
		if (r < RADIX_MIN)
			res = RADIX_MIN;
		else if (r > RADIX_MAX)
			res = RADIX_MAX;
		return res;
	endfunction

	// Digit value of a character; the flag is low for anything that is no digit.
	function automatic logic [6:0] digit_of(input logic [7:0] c);
		logic [6:0] res;
		res = '0;
		if (c inside {[CH_ZERO:CH_NINE]})
			res = {1'b1, 6'(c - CH_ZERO)};
		else if (c inside {[CH_LOWER_A:CH_LOWER_Z]})
			res = {1'b1, 6'(c - CH_LOWER_A) + LETTER_BASE};
		else if (c inside {[CH_UPPER_A:CH_UPPER_Z]})
			res = {1'b1, 6'(c - CH_UPPER_A) + LETTER_BASE};
		return res;
	endfunction

endpackage

// ===== hdl/rnp_front.sv =====
// Front end: takes bytes from the input stream and classifies them.
module rnp_front (
	input  logic              s_valid,
	output logic              s_ready,
	input  logic [7:0]        char_in,
	input  logic              restart,
	input  logic [5:0]        radix,
	input  logic              allow_minus,
	input  logic              q_full,
	output logic              push,
	output rnp_pkg::rnp_item_t item
);
	import rnp_pkg::*;

	logic [6:0] dv;
	logic [5:0] base;

	assign base    = clamp_radix(radix);
	assign dv      = digit_of(char_in);
	assign s_ready = !q_full;
	assign push    = s_valid && !q_full;

	always_comb begin
		item.char_in  = char_in;
		item.restart  = restart;
		item.digit    = dv[5:0];
		item.is_digit = dv[6] && (dv[5:0] < base);
		item.minus_ok = (char_in == CH_MINUS) && allow_minus;
	end

endmodule

// ===== hdl/rnp_queue.sv =====
// Short queue of classified bytes between the front end and the back end.
module rnp_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  rnp_pkg::rnp_item_t wr_item,
	output logic               full,
	input  logic               pop,
	output logic               not_empty,
	output rnp_pkg::rnp_item_t rd_item
);
	import rnp_pkg::*;

	localparam int DEPTH = 4;
	localparam int PW    = $clog2(DEPTH);

	rnp_item_t      mem_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [PW:0]    count_q;
	logic           do_pop;

	assign full      = (count_q == (PW+1)'(DEPTH));
	assign not_empty = (count_q != '0);
	assign rd_item   = mem_q[rd_ptr_q];
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (!push && do_pop)
				count_q <= count_q - 1'b1;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("queue written while full");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (PW+1)'(DEPTH))
		else $error("queue count beyond depth");

endmodule

// ===== hdl/rnp_back.sv =====
// Back end: number state, multiply-add of each digit, and the result register.
module rnp_back #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   q_valid,
	input  rnp_pkg::rnp_item_t     item,
	output logic                   pop,
	input  logic [5:0]             radix,
	input  logic [5:0]             max_digits,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [1:0]             status,
	output logic [VALUE_WIDTH-1:0] value,
	output logic                   is_negative,
	output logic [7:0]             end_byte,
	output logic [5:0]             digit_count
);
	import rnp_pkg::*;

	logic [VALUE_WIDTH-1:0] acc_q;
	logic [5:0]             cnt_q;
	logic                   neg_q;
	logic                   out_valid_q;
	logic [1:0]             status_q;
	logic [VALUE_WIDTH-1:0] value_q;
	logic                   neg_out_q;
	logic [7:0]             end_byte_q;
	logic [5:0]             count_out_q;

	logic [VALUE_WIDTH-1:0] acc;
	logic [5:0]             cnt;
	logic                   neg;
	logic [5:0]             base;
	logic [VALUE_WIDTH+5:0] prod;
	logic [VALUE_WIDTH-1:0] acc_next;
	logic                   res;
	logic [1:0]             res_status;
	logic                   take_digit;
	logic                   take_minus;

	assign pop  = q_valid && (!out_valid_q || out_ready);
	assign base = clamp_radix(radix);

	// State as seen by this byte, after an optional restart.
	assign acc = item.restart ? '0 : acc_q;
	assign cnt = item.restart ? '0 : cnt_q;
	assign neg = item.restart ? 1'b0 : neg_q;

	assign prod     = acc * base;
	assign acc_next = prod[VALUE_WIDTH-1:0] + VALUE_WIDTH'(item.digit);

	always_comb begin
		res        = 1'b0;
		res_status = ST_OTHER;
		take_digit = 1'b0;
		take_minus = 1'b0;
		if (item.is_digit) begin
			if (cnt < max_digits) begin
				take_digit = 1'b1;
			end else begin
				res        = 1'b1;
				res_status = ST_TOO_MANY;
			end
		end else if (cnt == '0) begin
			if (item.minus_ok) begin
				take_minus = 1'b1;
			end else begin
				res        = 1'b1;
				res_status = ST_NO_NUMBER;
			end
		end else begin
			res        = 1'b1;
			res_status = ST_OTHER;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			cnt_q       <= '0;
			neg_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				if (res) begin
					acc_q <= '0;
					cnt_q <= '0;
					neg_q <= 1'b0;
				end else if (take_digit) begin
					acc_q <= acc_next;
					cnt_q <= cnt + 1'b1;
					neg_q <= neg;
				end else begin
					acc_q <= acc;
					cnt_q <= cnt;
					neg_q <= neg || take_minus;
				end
			end
			if (pop && res)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && res) begin
			status_q    <= res_status;
			value_q     <= acc;
			neg_out_q   <= neg;
			end_byte_q  <= item.char_in;
			count_out_q <= cnt;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign value       = value_q;
	assign is_negative = neg_out_q;
	assign end_byte    = end_byte_q;
	assign digit_count = count_out_q;

	a_clear_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && res) |=> (cnt_q == '0 && acc_q == '0 && !neg_q))
		else $error("number state not cleared after a result");

	a_pop_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (!out_valid_q || out_ready))
		else $error("byte taken while the result register is blocked");

	a_result_from_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid_q ##1 out_valid_q) |-> $past(pop && res))
		else $error("result appeared without a finished number");

endmodule

// ===== hdl/radix_number_parser_unit.sv =====
// Top level of the radix number parser: ports, configuration registers, parts.
//
// The block reads a text stream one byte per transfer on the slave side
// (s_axis_*) and builds an unsigned integer in a base from 2 to 36. When a
// number ends, one result transfer leaves on the master side (m_axis_*)
// with its status, value, sign flag, ending byte and digit count. Bytes that
// extend a number, or a leading minus sign, give no result.
// Configuration goes through the cfg_* channel: index 0 sets the base,
// index 1 the digit limit and index 2 whether a leading minus is accepted.
// It is always ready and should be written only while the block is idle.
// Throughput is one byte per clock cycle while the master side does not stall;
// the back end does the digit multiply-add for each byte as it takes it from
// the queue. A result is registered when the back end takes the byte that
// ended the number, after that byte has passed through the queue.
// A four-entry queue sits between the classifying front end and the back
// end; while the master side stalls, the queue fills and then s_axis_tready
// falls, so no byte or result is lost.
// Reset clears the number state and the queue and loads the default
// configuration: base 10, a limit of ten digits and minus allowed.
module radix_number_parser_unit #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic clk,
	input  logic arst_n,

	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // char_in
	input  logic       s_axis_tuser,  // restart

	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// value, is_negative, end_byte, digit_count from bit 0 up, zero padded
	output logic [((VALUE_WIDTH+15+7)/8)*8-1:0] m_axis_tdata,
	output logic [1:0] m_axis_tuser,  // status

	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [5:0] cfg_data
);
	import rnp_pkg::*;

	localparam int OUT_W = ((VALUE_WIDTH + 15 + 7) / 8) * 8;

	logic [5:0] radix_q;
	logic [5:0] max_digits_q;
	logic       allow_minus_q;

	rnp_item_t  front_item;
	rnp_item_t  head_item;
	logic       push;
	logic       q_full;
	logic       q_valid;
	logic       pop;

	logic [1:0]             status;
	logic [VALUE_WIDTH-1:0] value;
	logic                   is_negative;
	logic [7:0]             end_byte;
	logic [5:0]             digit_count;

	// The configuration registers accept a write in every cycle; an index
	// beyond the list is taken and ignored.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q       <= RADIX_RESET;
			max_digits_q  <= MAX_DIGITS_RESET;
			allow_minus_q <= ALLOW_MINUS_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_RADIX:       radix_q       <= cfg_data;
				CFG_MAX_DIGITS:  max_digits_q  <= cfg_data;
				CFG_ALLOW_MINUS: allow_minus_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Front end: classifies each byte against the current base.
	rnp_front u_front (
		.s_valid     (s_axis_tvalid),
		.s_ready     (s_axis_tready),
		.char_in     (s_axis_tdata),
		.restart     (s_axis_tuser),
		.radix       (radix_q),
		.allow_minus (allow_minus_q),
		.q_full      (q_full),
		.push        (push),
		.item        (front_item)
	);

	// Queue that decouples the front end from the back end.
	rnp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_item   (front_item),
		.full      (q_full),
		.pop       (pop),
		.not_empty (q_valid),
		.rd_item   (head_item)
	);

	// Back end: accumulates digits and registers each finished number.
	rnp_back #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.item        (head_item),
		.pop         (pop),
		.radix       (radix_q),
		.max_digits  (max_digits_q),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.status      (status),
		.value       (value),
		.is_negative (is_negative),
		.end_byte    (end_byte),
		.digit_count (digit_count)
	);

	assign m_axis_tuser = status;
	assign m_axis_tdata = OUT_W'({digit_count, end_byte, is_negative, value});

endmodule
